// ===== sv/elrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Extent list read splitter package
// Shared types and fixed constants for the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package elrs_pkg;

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLIP,
    ST_WALK,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic write_ext;
    logic clip;
    logic skip;
    logic piece;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_end;
    logic walk_piece;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/extent_list_read_splitter_top.sv =====
// Load request: written into the extent table, no result.
// Read request: accepted, clipped, then a walk of the extent table (up to MAX_EXTENTS entries),
// a step to detect the end of the walk and the final result; no new request is taken before the
// final result. The walk visits one table entry per cycle while the output register can take
// each new piece. The last result of a request may wait in the output register.
// Reset clears the extent valid bits (all lengths read as zero) and sets file_size to zero.
// ----------------------------------------------------------------------------
// Extent list read splitter
// Maps logical file reads through an extent table into disk read commands.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_list_read_splitter_top #(
  parameter int unsigned MAX_EXTENTS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [3:0]                  extent_index_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] extent_start_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] extent_length_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] request_offset_i,
  input  wire logic [elrs_pkg::LEN_W-1:0]  request_length_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [elrs_pkg::ADDR_W-1:0]      disk_offset_o,
  output logic [elrs_pkg::LEN_W-1:0]       piece_length_o,
  output logic [elrs_pkg::LEN_W-1:0]       buffer_offset_o,
  output logic                             last_o,
  output logic                             short_read_o
);

  elrs_pkg::cmd_t cmd;
  elrs_pkg::sts_t sts;

  elrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  elrs_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .extent_index_i   (extent_index_i),
    .extent_start_i   (extent_start_i),
    .extent_length_i  (extent_length_i),
    .request_offset_i (request_offset_i),
    .request_length_i (request_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .disk_offset_o    (disk_offset_o),
    .piece_length_o   (piece_length_o),
    .buffer_offset_o  (buffer_offset_o),
    .last_o           (last_o),
    .short_read_o     (short_read_o)
  );

  // No piece is left staged once the block is ready for a new request.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.pend_valid)
    else $error("staged piece left behind at end of request");

  // Finishing a request always presents a result marked last.
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> (out_valid_o && last_o))
    else $error("final result missing or not marked last");

  // A piece pushed out by a newer one is never marked last.
  a_push_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.piece && sts.pend_valid) |=> (out_valid_o && !last_o && !short_read_o))
    else $error("intermediate piece carries end marks");

  // A result that is not the last one only appears while a request is in progress.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> in_stall_o)
    else $error("intermediate result outside a request");

endmodule

`default_nettype wire

// ===== sv/elrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Extent list read splitter controller
// Sequences one request at a time: clip, walk of the extent table, final result.
// ----------------------------------------------------------------------------
`default_nettype none

module elrs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          operation_i,
  output logic               in_stall_o,
  input  wire elrs_pkg::sts_t sts_i,
  output elrs_pkg::cmd_t     cmd_o
);

  elrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= elrs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      elrs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (operation_i == elrs_pkg::OP_READ) begin
            cmd_o.load_req = 1'b1;
            state_d        = elrs_pkg::ST_CLIP;
          end else begin
            cmd_o.write_ext = 1'b1;
          end
        end
      end
      elrs_pkg::ST_CLIP: begin
        cmd_o.clip = 1'b1;
        state_d    = elrs_pkg::ST_WALK;
      end
      elrs_pkg::ST_WALK: begin
        if (sts_i.walk_end) begin
          state_d = elrs_pkg::ST_FIN;
        end else if (sts_i.walk_piece) begin
          // A new piece may only displace the staged one if the output can take it.
          if (!sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.piece = 1'b1;
          end
        end else begin
          cmd_o.skip = 1'b1;
        end
      end
      elrs_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = elrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = elrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/elrs_dp.sv =====
// ----------------------------------------------------------------------------
// Extent list read splitter datapath
// Extent table, request registers, staged piece and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module elrs_dp #(
  parameter int unsigned MAX_EXTENTS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire elrs_pkg::cmd_t                cmd_i,
  output elrs_pkg::sts_t                     sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  wire logic [3:0]                    extent_index_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0]   extent_start_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0]   extent_length_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0]   request_offset_i,
  input  wire logic [elrs_pkg::LEN_W-1:0]    request_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [elrs_pkg::ADDR_W-1:0]        disk_offset_o,
  output logic [elrs_pkg::LEN_W-1:0]         piece_length_o,
  output logic [elrs_pkg::LEN_W-1:0]         buffer_offset_o,
  output logic                               last_o,
  output logic                               short_read_o
);

  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned IW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned DW = elrs_pkg::ADDR_W;
  localparam int unsigned LW = elrs_pkg::LEN_W;
  localparam int unsigned CW = elrs_pkg::CNT_W;

  // Extent table.
  logic [DW-1:0]          mem_start [MAX_EXTENTS];
  logic [DW-1:0]          mem_len   [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] valid_q;

  logic [DW-1:0] rd_start_q;
  logic [DW-1:0] rd_len_q;
  logic          rd_valid_q;

  logic [DW-1:0] file_size_q;
  logic [DW-1:0] offset_q;
  logic [LW-1:0] remain_q;
  logic [LW-1:0] buf_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] cnt_q;

  logic          pend_valid_q;
  logic [DW-1:0] pend_disk_q;
  logic [LW-1:0] pend_len_q;
  logic [LW-1:0] pend_buf_q;

  logic          out_valid_q;
  logic [DW-1:0] out_disk_q;
  logic [LW-1:0] out_len_q;
  logic [LW-1:0] out_buf_q;
  logic          out_last_q;
  logic          out_short_q;

  logic [31:0]   wr_idx;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [IW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic [DW-1:0] elen;
  logic [DW-1:0] avail;
  logic [LW-1:0] size;
  logic [DW-1:0] span;
  logic          req_empty;
  logic          out_free;
  logic          out_load;

  assign wr_idx  = 32'(extent_index_i);
  assign wr_en   = cmd_i.write_ext && (wr_idx < MAX_EXTENTS);
  assign wr_addr = wr_idx[AW-1:0];

  // The table is read one entry ahead of the walk so that the data is ready.
  assign rd_idx      = (cmd_i.skip || cmd_i.piece) ? idx_q + IW'(1) : idx_q;
  assign rd_addr     = rd_idx[AW-1:0];
  assign rd_in_range = 32'(rd_idx) < MAX_EXTENTS;

  // An entry that was never loaded reads as zero length, which ends the list.
  assign elen  = rd_valid_q ? rd_len_q : '0;
  assign avail = elen - offset_q;
  assign size  = (avail < {{(DW-LW){1'b0}}, remain_q}) ? avail[LW-1:0] : remain_q;

  assign span      = file_size_q - offset_q;
  assign req_empty = (offset_q >= file_size_q) || (remain_q == '0);

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (cmd_i.piece && pend_valid_q) || cmd_i.fin;

  always_comb begin
    sts_o            = '0;
    sts_o.walk_piece = offset_q < elen;
    sts_o.walk_end   = (32'(idx_q) == MAX_EXTENTS) || (elen == '0) || (remain_q == '0) ||
                       ((offset_q < elen) && (32'(cnt_q) == elrs_pkg::MAX_RESULTS));
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_start[wr_addr] <= extent_start_i;
      mem_len[wr_addr]   <= extent_length_i;
    end
    rd_start_q <= mem_start[rd_addr];
    rd_len_q   <= mem_len[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      rd_valid_q   <= 1'b0;
      file_size_q  <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      rd_valid_q <= rd_in_range ? valid_q[rd_addr] : 1'b0;
      if (cfg_we_i) begin
        file_size_q <= cfg_wdata_i;
      end
      if (cmd_i.load_req) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.skip || cmd_i.piece) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.piece) begin
        cnt_q        <= cnt_q + CW'(1);
        pend_valid_q <= 1'b1;
      end else if (cmd_i.fin || cmd_i.load_req) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      offset_q <= request_offset_i;
      remain_q <= request_length_i;
      buf_q    <= '0;
    end else if (cmd_i.clip) begin
      if (req_empty) begin
        remain_q <= '0;
      end else if ({{(DW-LW){1'b0}}, remain_q} > span) begin
        remain_q <= span[LW-1:0];
      end
    end else if (cmd_i.skip) begin
      offset_q <= offset_q - elen;
    end else if (cmd_i.piece) begin
      pend_disk_q <= rd_start_q + offset_q;
      pend_len_q  <= size;
      pend_buf_q  <= buf_q;
      remain_q    <= remain_q - size;
      buf_q       <= buf_q + size;
      offset_q    <= '0;
    end

    if (out_load) begin
      if (pend_valid_q) begin
        out_disk_q <= pend_disk_q;
        out_len_q  <= pend_len_q;
        out_buf_q  <= pend_buf_q;
      end else begin
        out_disk_q <= '0;
        out_len_q  <= '0;
        out_buf_q  <= '0;
      end
      out_last_q  <= cmd_i.fin;
      out_short_q <= cmd_i.fin && (remain_q != '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign disk_offset_o   = out_disk_q;
  assign piece_length_o  = out_len_q;
  assign buffer_offset_o = out_buf_q;
  assign last_o          = out_last_q;
  assign short_read_o    = out_short_q;

endmodule

`default_nettype wire

// ===== tb/sv/extent_list_read_splitter_checker.sv =====
// ----------------------------------------------------------------------------
// Extent list read splitter checker
// Watches the register port and both request channels, predicts the disk read
// commands of every read request from its own copy of the extent table and
// compares each delivered command with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_list_read_splitter_checker #(
  parameter int unsigned MAX_EXTENTS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_i,
  input  wire logic                        operation_i,
  input  wire logic [3:0]                  extent_index_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] extent_start_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] extent_length_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] request_offset_i,
  input  wire logic [elrs_pkg::LEN_W-1:0]  request_length_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_stall_i,
  input  wire logic [elrs_pkg::ADDR_W-1:0] disk_offset_i,
  input  wire logic [elrs_pkg::LEN_W-1:0]  piece_length_i,
  input  wire logic [elrs_pkg::LEN_W-1:0]  buffer_offset_i,
  input  wire logic                        last_i,
  input  wire logic                        short_read_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import elrs_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] disk_offset;
    logic [LEN_W-1:0]  piece_length;
    logic [LEN_W-1:0]  buffer_offset;
    logic              last;
    logic              short_read;
  } disk_cmd_t;

  logic [ADDR_W-1:0] file_size_q;
  logic [ADDR_W-1:0] ext_start_q [MAX_EXTENTS];
  logic [ADDR_W-1:0] ext_len_q   [MAX_EXTENTS];
  disk_cmd_t         expected_cmds [$];
  disk_cmd_t         seen_cmd;
  disk_cmd_t         due_cmd;
  int unsigned       reported;

  // Maps one read request through the extent table into disk read commands.
  task automatic split_read(input logic [ADDR_W-1:0] req_off,
                            input logic [LEN_W-1:0]  req_len);
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] remaining;
    logic [ADDR_W-1:0] chunk;
    logic [LEN_W-1:0]  buf_pos;
    int unsigned       produced;
    disk_cmd_t         held;
    disk_cmd_t         empty_cmd;
    empty_cmd      = '0;
    empty_cmd.last = 1'b1;
    if (req_off >= file_size_q || req_len == '0) begin
      expected_cmds.push_back(empty_cmd);
      return;
    end
    off       = req_off;
    remaining = {{(ADDR_W-LEN_W){1'b0}}, req_len};
    if (remaining > file_size_q - req_off) remaining = file_size_q - req_off;
    buf_pos  = '0;
    produced = 0;
    held     = '0;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (remaining == '0 || ext_len_q[i] == '0) break;
      if (off < ext_len_q[i]) begin
        if (produced >= MAX_RESULTS) break;
        chunk = remaining;
        if (chunk > ext_len_q[i] - off) chunk = ext_len_q[i] - off;
        // The previous piece is now known not to be the final one.
        if (produced != 0) expected_cmds.push_back(held);
        held.disk_offset   = ext_start_q[i] + off;
        held.piece_length  = chunk[LEN_W-1:0];
        held.buffer_offset = buf_pos;
        held.last          = 1'b0;
        held.short_read    = 1'b0;
        produced++;
        remaining = remaining - chunk;
        buf_pos   = buf_pos + chunk[LEN_W-1:0];
        off       = '0;
      end else begin
        off = off - ext_len_q[i];
      end
    end
    if (produced == 0) begin
      empty_cmd.short_read = (remaining != '0);
      expected_cmds.push_back(empty_cmd);
    end else begin
      held.last       = 1'b1;
      held.short_read = (remaining != '0);
      expected_cmds.push_back(held);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q = '0;
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        ext_start_q[i] = '0;
        ext_len_q[i]   = '0;
      end
      expected_cmds.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      reported         = 0;
    end else begin
      if (cfg_we_i) file_size_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_LOAD) begin
          if (extent_index_i < MAX_EXTENTS) begin
            ext_start_q[extent_index_i] = extent_start_i;
            ext_len_q[extent_index_i]   = extent_length_i;
          end
        end else begin
          split_read(request_offset_i, request_length_i);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        seen_cmd = {disk_offset_i, piece_length_i, buffer_offset_i, last_i, short_read_i};
        if (expected_cmds.size() == 0) begin
          mismatch_count_o++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected command disk %h len %h buf %h last %b short %b",
                     $realtime, seen_cmd.disk_offset, seen_cmd.piece_length,
                     seen_cmd.buffer_offset, seen_cmd.last, seen_cmd.short_read);
          end
        end else begin
          due_cmd = expected_cmds.pop_front();
          if (due_cmd.disk_offset   !== seen_cmd.disk_offset   ||
              due_cmd.piece_length  !== seen_cmd.piece_length  ||
              due_cmd.buffer_offset !== seen_cmd.buffer_offset ||
              due_cmd.last          !== seen_cmd.last          ||
              due_cmd.short_read    !== seen_cmd.short_read) begin
            mismatch_count_o++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch exp disk %h len %h buf %h last %b short %b",
                       $realtime, due_cmd.disk_offset, due_cmd.piece_length,
                       due_cmd.buffer_offset, due_cmd.last, due_cmd.short_read);
              $display("%0t:          got disk %h len %h buf %h last %b short %b",
                       $realtime, seen_cmd.disk_offset, seen_cmd.piece_length,
                       seen_cmd.buffer_offset, seen_cmd.last, seen_cmd.short_read);
            end
          end
        end
      end
      pending_o = expected_cmds.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_extent_list_read_splitter_top.sv =====
// ----------------------------------------------------------------------------
// Extent list read splitter testbench
// Drives extent loads, read requests and file size settings into the block,
// first a directed set of corner cases and then random traffic under several
// idling patterns, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_extent_list_read_splitter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import elrs_pkg::*;

  localparam int unsigned       MAX_EXTENTS  = 16;
  localparam int unsigned       DRAIN_CYCLES = MAX_EXTENTS + 8;
  localparam int unsigned       QUIET_LIMIT  = 2000;
  localparam logic [ADDR_W-1:0] ADDR_MAX     = {ADDR_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_MAX      = {LEN_W{1'b1}};

  logic              clk_i          = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_we         = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata      = '0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              operation      = OP_LOAD;
  logic [3:0]        extent_index   = '0;
  logic [ADDR_W-1:0] extent_start   = '0;
  logic [ADDR_W-1:0] extent_length  = '0;
  logic [ADDR_W-1:0] request_offset = '0;
  logic [LEN_W-1:0]  request_length = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [ADDR_W-1:0] disk_offset;
  logic [LEN_W-1:0]  piece_length;
  logic [LEN_W-1:0]  buffer_offset;
  logic              last;
  logic              short_read;

  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       sender_idle_pct    = 0;
  int unsigned       receiver_stall_pct = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  extent_list_read_splitter_top #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .extent_index_i  (extent_index),
    .extent_start_i  (extent_start),
    .extent_length_i (extent_length),
    .request_offset_i(request_offset),
    .request_length_i(request_length),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .disk_offset_o   (disk_offset),
    .piece_length_o  (piece_length),
    .buffer_offset_o (buffer_offset),
    .last_o          (last),
    .short_read_o    (short_read)
  );

  extent_list_read_splitter_checker #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .extent_index_i  (extent_index),
    .extent_start_i  (extent_start),
    .extent_length_i (extent_length),
    .request_offset_i(request_offset),
    .request_length_i(request_length),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .disk_offset_i   (disk_offset),
    .piece_length_i  (piece_length),
    .buffer_offset_i (buffer_offset),
    .last_i          (last),
    .short_read_i    (short_read),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input op_e               op,
                              input logic [3:0]        idx,
                              input logic [ADDR_W-1:0] start,
                              input logic [ADDR_W-1:0] len,
                              input logic [ADDR_W-1:0] roff,
                              input logic [LEN_W-1:0]  rlen);
    @(negedge clk_i);
    in_valid       <= 1'b1;
    operation      <= op;
    extent_index   <= idx;
    extent_start   <= start;
    extent_length  <= len;
    request_offset <= roff;
    request_length <= rlen;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic load_extent(input logic [3:0] idx, input logic [ADDR_W-1:0] start,
                             input logic [ADDR_W-1:0] len);
    send_request(OP_LOAD, idx, start, len, rand_addr(), $urandom);
  endtask

  task automatic read_file(input logic [ADDR_W-1:0] roff, input logic [LEN_W-1:0] rlen);
    send_request(OP_READ, 4'($urandom), rand_addr(), rand_addr(), roff, rlen);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // The block may still be busy with a read, so the register is touched only after every
  // predicted command has been delivered and a further drain wait has passed.
  task automatic set_file_size(input logic [ADDR_W-1:0] size);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  task automatic random_request();
    int unsigned       r;
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] roff;
    logic [LEN_W-1:0]  rlen;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      r = $urandom_range(0, 99);
      if (r < 10)      len = '0;
      else if (r < 15) len = rand_addr();
      else             len = ADDR_W'($urandom_range(1, 3000));
      load_extent(4'($urandom), rand_addr(), len);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) roff = rand_addr();
      else        roff = ADDR_W'($urandom_range(0, 40000));
      r = $urandom_range(0, 99);
      if (r < 10)      rlen = $urandom;
      else if (r < 13) rlen = '0;
      else             rlen = LEN_W'($urandom_range(1, 30000));
      read_file(roff, rlen);
    end
  endtask

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_n || in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] size;
    repeat (10) @(negedge clk_i);
    rst_n <= 1'b1;

    // File size is zero out of reset, so any read lies past the end.
    read_file('0, 32'd100);
    set_file_size(ADDR_MAX);
    // No extents yet: the request runs out before a single piece.
    read_file(48'h10, 32'd10);
    // The first extent runs past the top of the disk, so its pieces wrap.
    load_extent(4'd0, ADDR_MAX - 48'hFF, 48'h200);
    load_extent(4'd1, '0, ADDR_MAX);
    read_file(48'h100, 32'h200);
    read_file('0, '0);
    read_file(ADDR_MAX, LEN_MAX);
    read_file(48'h300, LEN_MAX);
    // A zero length in slot one cuts the list short.
    load_extent(4'd1, rand_addr(), '0);
    read_file('0, 32'h1000);
    read_file(48'h400, 32'd10);
    for (int i = 1; i < MAX_EXTENTS; i++) begin
      load_extent(4'(i), rand_addr(), ADDR_W'($urandom_range(1, 64)));
    end
    // Every slot is in use, so the table and the piece limit are both reached.
    read_file('0, LEN_MAX);
    set_file_size(48'h200 + 48'd30);
    read_file(48'h1F0, 32'd1000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 45;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 45;
        end
        default: begin
          sender_idle_pct    = 7;
          receiver_stall_pct = 7;
        end
      endcase
      for (int blk = 0; blk < 2; blk++) begin
        case ((phase * 2 + blk) % 4)
          0:       size = ADDR_MAX;
          1:       size = rand_addr();
          2:       size = ADDR_W'($urandom_range(1, 40000));
          default: size = (phase == 1) ? '0 : ADDR_W'($urandom_range(40000, 200000));
        endcase
        set_file_size(size);
        for (int n = 0; n < 13; n++) begin
          sender_gap();
          if ((phase == 1 && blk == 0 && n == 8) || $urandom_range(0, 99) < 3) begin
            hold_until_drained();
          end
          random_request();
        end
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
